// File: design/sha_pkg.sv
// Shared constants and functions for the SHA-256 digest prefix block.
// Depends on nothing; used by every module in this folder.
`default_nettype none
package sha_pkg;
  localparam int COUNT_BITS = 32;
  localparam int QDEPTH = 4;
  localparam int QAW = 2;
  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS = 6'd56;

  typedef struct packed {
    logic [7:0] data;
    logic       has;
    logic       last;
  } req_t;

  typedef logic [31:0] word_t;

  localparam word_t INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t rotr(input word_t x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction
endpackage
`default_nettype wire

// File: design/sha_front.sv
// Input side: accepts requests and drops those that carry nothing.
// Depends on sha_pkg; feeds sha_queue.
`default_nettype none
module sha_front (
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire sha_pkg::req_t in_req,
  output logic               push,
  output sha_pkg::req_t      push_req,
  input  wire logic          full
);
  assign in_stall = full;
  assign push = in_valid && !full && (in_req.has || in_req.last);
  assign push_req = in_req;
endmodule
`default_nettype wire

// File: design/sha_queue.sv
// Short request queue between the front and the compression engine.
// Depends on sha_pkg.
`default_nettype none
module sha_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire sha_pkg::req_t push_req,
  output logic               full,
  output logic               nonempty,
  input  wire logic          pop,
  output sha_pkg::req_t      head
);
  sha_pkg::req_t mem_r [sha_pkg::QDEPTH];
  logic [sha_pkg::QAW-1:0] wp_r, rp_r;
  logic [sha_pkg::QAW:0] cnt_r;
  assign full = cnt_r == (sha_pkg::QAW+1)'(sha_pkg::QDEPTH);
  assign nonempty = cnt_r != '0;
  assign head = mem_r[rp_r];
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_req;
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (sha_pkg::QAW+1)'(push) - (sha_pkg::QAW+1)'(pop);
    end
  end
endmodule
`default_nettype wire

// File: design/sha_back.sv
// Back end: packs bytes, pads, runs one SHA-256 round per cycle, drives results.
// Depends on sha_pkg; fed by sha_queue.
`default_nettype none
module sha_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          nonempty,
  input  wire sha_pkg::req_t head,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [63:0]        out_digest_prefix,
  output logic               out_length_overflow
);
  localparam logic [2:0] S_IDLE = 3'd0, S_PAD = 3'd1, S_RUN = 3'd2, S_FIN = 3'd3,
    S_LEN = 3'd4;
  logic [2:0] st_r;
  sha_pkg::word_t blk_r [16];
  sha_pkg::word_t h_r [8];
  sha_pkg::word_t v_r [8];
  logic [sha_pkg::COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic ovf_r, fin_r, two_r, pad_r;
  logic [5:0] t_r;
  logic [5:0] pos;
  logic [3:0] wi;
  logic [4:0] sh;
  sha_pkg::word_t w, s0, s1, S0, S1, ch, mj, t1;
  logic [63:0] bits;

  assign pos = cnt_r[5:0];
  assign wi = pos[5:2];
  assign sh = 5'((2'd3 - pos[1:0]) * 8);
  assign cnt_nxt = cnt_r + 1'b1;
  assign bits = 64'(cnt_r) << 3;
  assign pop = (st_r == S_IDLE) && nonempty && !(out_valid && out_stall);

  always_comb begin
    s0 = sha_pkg::rotr(blk_r[1], 7) ^ sha_pkg::rotr(blk_r[1], 18) ^ (blk_r[1] >> 3);
    s1 = sha_pkg::rotr(blk_r[14], 17) ^ sha_pkg::rotr(blk_r[14], 19) ^ (blk_r[14] >> 10);
    w = blk_r[0];
    S1 = sha_pkg::rotr(v_r[4], 6) ^ sha_pkg::rotr(v_r[4], 11) ^ sha_pkg::rotr(v_r[4], 25);
    ch = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    t1 = v_r[7] + S1 + ch + sha_pkg::ROUND_K[t_r] + w;
    S0 = sha_pkg::rotr(v_r[0], 2) ^ sha_pkg::rotr(v_r[0], 13) ^ sha_pkg::rotr(v_r[0], 22);
    mj = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      cnt_r <= '0;
      ovf_r <= 1'b0;
      out_valid <= 1'b0;
      fin_r <= 1'b0;
      two_r <= 1'b0;
      pad_r <= 1'b0;
      t_r <= '0;
      for (int i = 0; i < 8; i++) begin
        h_r[i] <= sha_pkg::INIT_HASH[i];
        v_r[i] <= '0;
      end
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (st_r)
        S_IDLE: begin
          if (pop) begin
            if (head.has) begin
              if (pos[1:0] == 2'd0) blk_r[wi] <= {head.data, 24'd0};
              else blk_r[wi] <= blk_r[wi] | (32'(head.data) << sh);
              cnt_r <= cnt_nxt;
              if (cnt_nxt == '0) ovf_r <= 1'b1;
            end
            fin_r <= head.last;
            if (head.has && pos == 6'd63) begin
              st_r <= S_RUN;
              t_r <= '0;
              for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
            end else if (head.last) st_r <= S_PAD;
          end
        end
        S_PAD: begin
          if (pos[1:0] == 2'd0) blk_r[wi] <= {sha_pkg::PAD_BYTE, 24'd0};
          else blk_r[wi] <= blk_r[wi] | (32'(sha_pkg::PAD_BYTE) << sh);
          for (int i = 0; i < 16; i++)
            if (4'(i) > wi) blk_r[i] <= '0;
          two_r <= pos >= sha_pkg::LEN_POS;
          pad_r <= 1'b1;
          if (pos < sha_pkg::LEN_POS) begin
            blk_r[14] <= bits[63:32];
            blk_r[15] <= bits[31:0];
          end
          st_r <= S_RUN;
          t_r <= '0;
          for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
        end
        S_RUN: begin
          for (int i = 0; i < 15; i++) blk_r[i] <= blk_r[i+1];
          blk_r[15] <= blk_r[0] + s0 + blk_r[9] + s1;
          v_r[7] <= v_r[6];
          v_r[6] <= v_r[5];
          v_r[5] <= v_r[4];
          v_r[4] <= v_r[3] + t1;
          v_r[3] <= v_r[2];
          v_r[2] <= v_r[1];
          v_r[1] <= v_r[0];
          v_r[0] <= t1 + S0 + mj;
          t_r <= t_r + 1'b1;
          if (t_r == 6'd63) st_r <= S_FIN;
        end
        S_FIN: begin
          for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
          if (!fin_r) st_r <= S_IDLE;
          else if (!pad_r) st_r <= S_PAD;
          else if (two_r) begin
            two_r <= 1'b0;
            st_r <= S_LEN;
          end else begin
            out_digest_prefix <= {h_r[0] + v_r[0], h_r[1] + v_r[1]};
            out_length_overflow <= ovf_r;
            out_valid <= 1'b1;
            for (int i = 0; i < 8; i++) h_r[i] <= sha_pkg::INIT_HASH[i];
            cnt_r <= '0;
            ovf_r <= 1'b0;
            fin_r <= 1'b0;
            pad_r <= 1'b0;
            st_r <= S_IDLE;
          end
        end
        S_LEN: begin
          for (int i = 0; i < 14; i++) blk_r[i] <= '0;
          blk_r[14] <= bits[63:32];
          blk_r[15] <= bits[31:0];
          st_r <= S_RUN;
          t_r <= '0;
          for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: design/sha256_digest_prefix_top.sv
// SHA-256 digest prefix top level: front, request queue and compression engine.
// A byte that does not complete a block is simply stored; a byte that completes a block runs
// it through the single-round engine, and a last request adds padding and one or two blocks.
// Synchronous active-low reset loads the initial hash and empties the queue.
`default_nettype none
module sha256_digest_prefix_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_message_byte,
  input  wire logic        in_has_byte,
  input  wire logic        in_last_item,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      out_digest_prefix,
  output logic             out_length_overflow
);
  sha_pkg::req_t in_req, push_req, head;
  logic push, full, nonempty, pop;
  assign in_req = '{data: in_message_byte, has: in_has_byte, last: in_last_item};

  sha_front u_front (.in_valid(in_valid), .in_stall(in_stall),
    .in_req(in_req), .push(push), .push_req(push_req), .full(full));
  sha_queue u_queue (.clk(clk), .rst_n(rst_n), .push(push), .push_req(push_req),
    .full(full), .nonempty(nonempty), .pop(pop), .head(head));
  sha_back u_back (.clk(clk), .rst_n(rst_n), .nonempty(nonempty), .head(head), .pop(pop),
    .out_valid(out_valid), .out_stall(out_stall), .out_digest_prefix(out_digest_prefix),
    .out_length_overflow(out_length_overflow));
endmodule
`default_nettype wire

// File: tb/sv/tb_top.sv
// Self-checking testbench for the SHA-256 digest prefix block.
// Byte streams are sent through the valid/stall request channel, and each digest is checked
// against a SystemVerilog SHA-256 predictor. Uses sha_pkg and sha256_digest_prefix_top.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       has;
    logic       last;
  } byte_req_t;

  typedef struct packed {
    logic [63:0] digest;
    logic        ovf;
  } digest_t;

  typedef struct {
    byte_req_t   req;
    bit          known;
    logic [63:0] digest;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_message_byte;
  logic        in_has_byte;
  logic        in_last_item;
  logic        out_valid;
  logic        out_stall;
  logic [63:0] out_digest_prefix;
  logic        out_length_overflow;

  sha256_digest_prefix_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_message_byte(in_message_byte), .in_has_byte(in_has_byte),
    .in_last_item(in_last_item),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_digest_prefix(out_digest_prefix), .out_length_overflow(out_length_overflow)
  );

  sha_pkg::word_t hash_q [8];
  sha_pkg::word_t block_q [16];
  logic [31:0] byte_cnt;
  bit          cnt_wrapped;
  digest_t     pending_digests [$];
  int          errors = 0;
  int          requests_sent = 0;
  int          digests_checked = 0;
  int          sender_idle = 0;
  int          receiver_idle = 0;
  bit          hold_go = 0;
  int          cycles = 0;

  function automatic sha_pkg::word_t ror32(sha_pkg::word_t x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic sha_compress();
    sha_pkg::word_t sched [64];
    sha_pkg::word_t v [8];
    sha_pkg::word_t t1;
    sha_pkg::word_t t2;
    for (int t = 0; t < 64; t++) begin
      if (t < 16) begin
        sched[t] = block_q[t];
      end else begin
        sched[t] = sched[t-16] + sched[t-7]
                 + (ror32(sched[t-15], 7) ^ ror32(sched[t-15], 18) ^ (sched[t-15] >> 3))
                 + (ror32(sched[t-2], 17) ^ ror32(sched[t-2], 19) ^ (sched[t-2] >> 10));
      end
    end
    for (int i = 0; i < 8; i++) v[i] = hash_q[i];
    for (int t = 0; t < 64; t++) begin
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha_pkg::ROUND_K[t] + sched[t];
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_q[i] += v[i];
  endtask

  task automatic place_byte(logic [5:0] pos, logic [7:0] b);
    if (pos[1:0] == 2'd0) begin
      block_q[pos[5:2]] = {b, 24'h0};
    end else begin
      block_q[pos[5:2]] |= sha_pkg::word_t'(b) << ((3 - pos[1:0]) * 8);
    end
  endtask

  task automatic clear_hash();
    for (int i = 0; i < 8; i++) hash_q[i] = sha_pkg::INIT_HASH[i];
    byte_cnt = '0;
    cnt_wrapped = 0;
  endtask

  // Advances the predictor by one accepted request; returns 1 when a digest is due.
  task automatic hash_absorb(byte_req_t r, output bit done, output digest_t d);
    logic [5:0]  pos;
    logic [63:0] bits;
    done = 0;
    d = '0;
    if (r.has) begin
      pos = byte_cnt[5:0];
      place_byte(pos, r.msg_byte);
      byte_cnt = byte_cnt + 1;
      if (byte_cnt == 0) cnt_wrapped = 1;
      if (pos == 6'd63) sha_compress();
    end
    if (r.last) begin
      pos = byte_cnt[5:0];
      place_byte(pos, sha_pkg::PAD_BYTE);
      for (int i = pos[5:2] + 1; i < 16; i++) block_q[i] = '0;
      if (pos >= sha_pkg::LEN_POS) begin
        sha_compress();
        for (int i = 0; i < 16; i++) block_q[i] = '0;
      end
      bits = {32'h0, byte_cnt} << 3;
      block_q[14] = bits[63:32];
      block_q[15] = bits[31:0];
      sha_compress();
      d.digest = {hash_q[0], hash_q[1]};
      d.ovf = cnt_wrapped;
      done = 1;
      clear_hash();
    end
  endtask

  task automatic send_req(byte_req_t r, bit known, logic [63:0] known_digest);
    bit      done;
    digest_t d;
    while ($urandom_range(99) < sender_idle) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_message_byte <= r.msg_byte;
    in_has_byte <= r.has;
    in_last_item <= r.last;
    do @(posedge clk); while (in_stall);
    requests_sent++;
    hash_absorb(r, done, d);
    if (done) begin
      if (known) d.digest = known_digest;
      pending_digests.push_back(d);
    end
  endtask

  task automatic send_message(int len, bit byte_on_last);
    byte_req_t r;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < 5) begin
        r = '{msg_byte: 8'($urandom), has: 1'b0, last: 1'b0};
        send_req(r, 0, '0);
      end
      r = '{msg_byte: 8'($urandom), has: 1'b1,
            last: (byte_on_last && i == len - 1)};
      send_req(r, 0, '0);
    end
    if (!byte_on_last || len == 0) begin
      r = '{msg_byte: 8'($urandom), has: 1'b0, last: 1'b1};
      send_req(r, 0, '0);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_digests.size() != 0) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 600000) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    int hold_left;
    out_stall = 1'b1;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_go && hold_left == 0) begin
        hold_left = 1500;
        hold_go = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < receiver_idle);
      end
    end
  end

  always @(posedge clk) begin
    digest_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_digests.size() == 0) begin
        $error("digest with no request waiting: %h", out_digest_prefix);
        errors++;
      end else begin
        e = pending_digests.pop_front();
        digests_checked++;
        if (out_digest_prefix !== e.digest) begin
          $error("digest_prefix: expected %h, actual %h", e.digest, out_digest_prefix);
          errors++;
        end
        if (out_length_overflow !== e.ovf) begin
          $error("length_overflow: expected %b, actual %b", e.ovf, out_length_overflow);
          errors++;
        end
      end
    end
  end

  initial begin
    dir_row_t  rows [$];
    byte_req_t r;
    int        sel;
    int        len;
    int        start_count;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_message_byte = '0;
    in_has_byte = 1'b0;
    in_last_item = 1'b0;
    clear_hash();
    for (int i = 0; i < 16; i++) block_q[i] = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    rows.push_back('{'{8'h00, 1'b0, 1'b0}, 0, 64'h0});
    rows.push_back('{'{8'h00, 1'b0, 1'b1}, 1, 64'he3b0c44298fc1c14});
    rows.push_back('{'{8'h61, 1'b1, 1'b0}, 0, 64'h0});
    rows.push_back('{'{8'h62, 1'b1, 1'b0}, 0, 64'h0});
    rows.push_back('{'{8'h63, 1'b1, 1'b1}, 1, 64'hba7816bf8f01cfea});
    rows.push_back('{'{8'hff, 1'b1, 1'b0}, 0, 64'h0});
    rows.push_back('{'{8'h5a, 1'b0, 1'b0}, 0, 64'h0});
    rows.push_back('{'{8'h00, 1'b1, 1'b0}, 0, 64'h0});
    rows.push_back('{'{8'hff, 1'b0, 1'b1}, 0, 64'h0});
    rows.push_back('{'{8'hff, 1'b1, 1'b1}, 0, 64'h0});
    rows.push_back('{'{8'h00, 1'b1, 1'b1}, 0, 64'h0});
    rows.push_back('{'{8'hff, 1'b0, 1'b1}, 1, 64'he3b0c44298fc1c14});
    foreach (rows[i]) send_req(rows[i].req, rows[i].known, rows[i].digest);
    wait_drained();

    for (int phase = 0; phase < 3; phase++) begin
      sender_idle = (phase == 0) ? 9 : (phase == 1) ? 77 : 0;
      receiver_idle = (phase == 0) ? 77 : (phase == 1) ? 9 : 0;
      if (phase == 2) begin
        hold_go = 1;
        for (int i = 0; i < 20; i++) begin
          r = '{msg_byte: 8'($urandom), has: 1'($urandom), last: 1'b1};
          send_req(r, 0, '0);
        end
      end
      start_count = requests_sent;
      while (requests_sent - start_count < 200) begin
        sel = $urandom_range(99);
        if (sel < 60) len = $urandom_range(12);
        else if (sel < 85) len = $urandom_range(72, 52);
        else if (sel < 95) len = $urandom_range(135, 110);
        else len = $urandom_range(3);
        send_message(len, $urandom_range(1));
      end
      wait_drained();
    end

    repeat (300) @(posedge clk);
    $display("Checked %0d digests from %0d requests, message lengths 0 to 135 bytes.",
             digests_checked, requests_sent);
    if (errors == 0 && pending_digests.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
